// ===== design/rbd_pkg.sv =====
// Shared constants and types of the run-length bitmap decoder.
`default_nettype none
package rbd_pkg;

  localparam int unsigned LenBits   = 24;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 3;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [7:0] CtrlSplit = 8'd128;

  localparam logic [1:0] ModeRepeat = 2'd1;
  localparam logic [1:0] ModeZero   = 2'd2;

  localparam logic RegMode   = 1'b0;
  localparam logic RegMaxLen = 1'b1;

  // One classified byte handed from the parser to the output stage.
  typedef struct packed {
    logic       start;
    logic       emit;
    logic [7:0] value;
    logic [6:0] want;
  } rbd_evt_t;

endpackage
`default_nettype wire

// ===== design/rbd_if.sv =====
// Valid/ready channel interfaces for compressed bytes and decoded tokens.
`default_nettype none
interface rbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       block_start;

  modport source (output valid, in_byte, block_start, input ready);
  modport sink   (input valid, in_byte, block_start, output ready);
endinterface

interface rbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic [6:0] run_count;
  logic       last;

  modport source (output valid, out_value, run_count, last, input ready);
  modport sink   (input valid, out_value, run_count, last, output ready);
endinterface
`default_nettype wire

// ===== design/rle_bitmap_decoder_unit.sv =====
// Top level of the run-length bitmap decoder with its register port.
//
// Usage: compressed bytes enter on in_i (valid/ready, with block_start on the
// first word of each block) and decoded runs leave on out_o as
// (out_value, run_count, last) tokens. mode and max_length are written over
// the APB port at byte addresses 0 and 4 while the decoder is idle.
// Throughput: one input word per cycle while the queue is not full. The
// parser classifies each word in the cycle it is accepted and writes it to a
// two-entry queue; the token stage clamps the run against the remaining length
// and loads the output register. Path: an accepted word is written to the
// queue, and its token is then loaded into the output register and presented.
// Stall: when out_o.ready is low the output register holds its token, the
// queue fills, and in_i.ready drops once the queue holds two words.
// Reset: mode and max_length clear to zero, the queue empties and the decoder
// starts as if a block had just begun; with max_length of zero nothing is produced.
`default_nettype none
module rle_bitmap_decoder_unit import rbd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  rbd_in_if.sink                in_i,
  rbd_out_if.source             out_o
);

  logic [1:0]         mode_q;
  logic [LenBits-1:0] max_length_q;
  logic               wr_en;
  rbd_evt_t           push_evt, pop_evt;
  logic               push_valid, push_ready, pop_valid, pop_ready;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == RegMaxLen) ? {{(DataW - LenBits){1'b0}}, max_length_q}
                                          : {{(DataW - 2){1'b0}}, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      max_length_q <= '0;
    end else if (wr_en) begin
      if (paddr[2] == RegMode) begin
        mode_q <= pwdata[1:0];
      end else begin
        max_length_q <= pwdata[LenBits-1:0];
      end
    end
  end

  rbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_i        (in_i),
    .evt_o       (push_evt),
    .evt_valid_o (push_valid),
    .evt_ready_i (push_ready)
  );

  rbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (push_evt),
    .ready_o (push_ready),
    .pop_i   (pop_ready),
    .data_o  (pop_evt),
    .valid_o (pop_valid)
  );

  rbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_length_i (max_length_q),
    .evt_i        (pop_evt),
    .evt_valid_i  (pop_valid),
    .evt_ready_o  (pop_ready),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

// ===== design/rbd_fifo.sv =====
// Short event queue between the byte parser and the token stage.
`default_nettype none
module rbd_fifo import rbd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  rbd_evt_t      data_i,
  output logic          ready_o,
  input  wire logic     pop_i,
  output rbd_evt_t      data_o,
  output logic          valid_o
);

  rbd_evt_t            mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/rbd_front.sv =====
// Byte parser: tracks control, literal and value phases and classifies each word.
`default_nettype none
module rbd_front import rbd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] mode_i,
  rbd_in_if.sink          in_i,
  output rbd_evt_t        evt_o,
  output logic            evt_valid_o,
  input  wire logic       evt_ready_i
);

  localparam logic [1:0] PhControl = 2'd0;
  localparam logic [1:0] PhLiteral = 2'd1;
  localparam logic [1:0] PhValue   = 2'd2;

  logic [1:0] phase_q, phase_d, ph;
  logic [7:0] lit_q, lit_d, lit;
  logic [6:0] pend_q, pend_d, pend;
  logic       accept;
  logic [7:0] b;

  assign in_i.ready  = evt_ready_i;
  assign evt_valid_o = in_i.valid;
  assign accept      = in_i.valid && evt_ready_i;
  assign b           = in_i.in_byte;

  always_comb begin
    // a block start clears the parser before the word is used
    ph   = in_i.block_start ? PhControl : phase_q;
    lit  = in_i.block_start ? 8'd0 : lit_q;
    pend = in_i.block_start ? 7'd0 : pend_q;

    phase_d     = ph;
    lit_d       = lit;
    pend_d      = pend;
    evt_o.start = in_i.block_start;
    evt_o.emit  = 1'b0;
    evt_o.value = b;
    evt_o.want  = 7'd1;

    if (mode_i != ModeRepeat && mode_i != ModeZero) begin
      evt_o.emit = 1'b1;
    end else begin
      unique case (ph)
        PhLiteral: begin
          lit_d = (lit == 8'd0) ? 8'd0 : lit - 8'd1;
          if (lit_d == 8'd0) begin
            phase_d = PhControl;
          end
          evt_o.emit = 1'b1;
        end
        PhValue: begin
          evt_o.emit = 1'b1;
          evt_o.want = pend;
          pend_d     = 7'd0;
          phase_d    = PhControl;
        end
        default: begin
          if (b <= CtrlSplit) begin
            lit_d   = b;
            phase_d = (b == 8'd0) ? PhControl : PhLiteral;
          end else if (mode_i == ModeZero) begin
            evt_o.emit  = 1'b1;
            evt_o.value = 8'd0;
            evt_o.want  = b[6:0];
          end else begin
            pend_d  = b[6:0];
            phase_d = PhValue;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhControl;
      lit_q   <= '0;
      pend_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      lit_q   <= lit_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/rbd_back.sv =====
// Token stage: clamps runs to the block length, flags the last token, drives the output.
`default_nettype none
module rbd_back import rbd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [LenBits-1:0] max_length_i,
  input  rbd_evt_t                evt_i,
  input  wire logic               evt_valid_i,
  output logic                    evt_ready_o,
  rbd_out_if.source               out_o
);

  logic [LenBits-1:0] produced_q, produced_d, prod, left, new_prod;
  logic               finished_q, finished_d, fin;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         value_q;
  logic [6:0]         count_q, cnt;
  logic               last_q, last_d, load;

  assign evt_ready_o     = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.out_value = value_q;
  assign out_o.run_count = count_q;
  assign out_o.last      = last_q;

  always_comb begin
    prod       = evt_i.start ? '0 : produced_q;
    fin        = evt_i.start ? 1'b0 : finished_q;
    left       = max_length_i - prod;
    cnt        = (left < LenBits'(evt_i.want)) ? left[6:0] : evt_i.want;
    new_prod   = prod + LenBits'(cnt);
    last_d     = (new_prod == max_length_i);
    produced_d = prod;
    finished_d = fin;
    load       = 1'b0;
    if (fin || prod >= max_length_i) begin
      // length reached: drop words until the next block start
      finished_d = 1'b1;
    end else if (evt_i.emit) begin
      load       = 1'b1;
      produced_d = new_prod;
      finished_d = last_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (evt_valid_i && evt_ready_o && load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produced_q  <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (evt_valid_i && evt_ready_o) begin
        produced_q <= produced_d;
        finished_q <= finished_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_valid_i && evt_ready_o && load) begin
      value_q <= evt_i.value;
      count_q <= cnt;
      last_q  <= last_d;
    end
  end

endmodule
`default_nettype wire
